// File: hw/rtl/mdt_pkg.sv
package mdt_pkg;

   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 20;
   localparam int TICK_W     = 48;
   localparam int READING_W  = 16;
   localparam int SECS_W     = 23;
   localparam int USECS_W    = 20;

   localparam logic [20:0]          TICKS_PER_SEC = 21'd1193180;
   localparam logic [9:0]           MS_PER_SEC    = 10'd1000;
   localparam logic [DIVISOR_W-1:0] US_PER_SEC    = 20'd1000000;
   localparam logic [7:0]           SCALE_A_MUL   = 8'd193;
   localparam logic [7:0]           SCALE_B_MUL   = 8'd180;
   localparam logic [READING_W-1:0] RELOAD_RESET  = 16'd11932;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_CHECK = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [31:0]           duration_ms;
      logic [READING_W-1:0]  counter_reading;
   } req_payload_type;

   typedef struct packed {
      logic               running;
      logic [TICK_W-1:0]  elapsed_ticks;
   } rsp_payload_type;

   typedef struct packed {
      logic                   start;
      logic [DIVIDEND_W-1:0]  dividend;
      logic [DIVISOR_W-1:0]   divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                   done;
      logic [DIVIDEND_W-1:0]  quotient;
      logic [DIVISOR_W-1:0]   remainder;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_SCALE_A,
      ST_SCALE_B,
      ST_SUM,
      ST_CHECK,
      ST_DONE
   } mdt_state_type;

endpackage

// File: hw/rtl/millisecond_deadline_timer_unit.sv
// Start transfer: three runs of the shared radix-4 divider, started on accept,
// in ST_SCALE_A and in ST_SCALE_B; ST_SUM and then ST_DONE load the result.
// Check transfer: ST_CHECK, then ST_DONE loads the result.
// One item at a time; a pending result does not block the next accept.
// Synchronous active-high reset: reload value 11932, timer expired with zero
// elapsed ticks, last reading zero, no result pending.
module millisecond_deadline_timer_unit
   import mdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [READING_W-1:0]  csr_write_data
);

   mdt_state_type          state_ff, state_in;
   mdt_state_type          after_ff, after_in;
   logic [READING_W-1:0]   reload_ff, reload_in;
   logic [READING_W-1:0]   last_ff, last_in;
   logic [TICK_W-1:0]      elapsed_ff, elapsed_in;
   logic [TICK_W-1:0]      target_ff, target_in;
   logic [READING_W-1:0]   reading_ff, reading_in;
   logic [TICK_W-1:0]      acc_ff, acc_in;
   logic [USECS_W-1:0]     usecs_ff, usecs_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_ff, rsp_in;

   div_cmd_type            div_cmd;
   div_status_type         div_status;

   logic                   req_take;
   logic                   rsp_free;
   logic [SECS_W+20:0]     secs_prod;
   logic [USECS_W-1:0]     usecs_calc;
   logic [27:0]            scale_a_prod;
   logic [27:0]            scale_b_prod;
   logic [READING_W-1:0]   diff;
   logic [READING_W-1:0]   delta;
   logic [TICK_W:0]        sum_wide;
   logic [TICK_W-1:0]      elapsed_sat;

   mdt_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .status (div_status)
   );

   assign req_take     = req_valid && !req_stall;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign secs_prod    = div_status.quotient[SECS_W-1:0] * TICKS_PER_SEC;
   assign usecs_calc   = div_status.remainder[9:0] * MS_PER_SEC;
   assign scale_a_prod = usecs_ff * SCALE_A_MUL;
   assign scale_b_prod = usecs_ff * SCALE_B_MUL;

   always_comb begin
      diff = READING_W'(reading_ff - last_ff);
      if (reading_ff > last_ff) begin
         delta = (reload_ff >= diff) ? READING_W'(reload_ff - diff) : '0;
      end else begin
         delta = READING_W'(last_ff - reading_ff);
      end
      sum_wide    = {1'b0, elapsed_ff} + (TICK_W + 1)'(delta);
      elapsed_sat = sum_wide[TICK_W] ? '1 : sum_wide[TICK_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      reload_in    = csr_write_enable ? csr_write_data : reload_ff;
      last_in      = last_ff;
      elapsed_in   = elapsed_ff;
      target_in    = target_ff;
      reading_in   = reading_ff;
      acc_in       = acc_ff;
      usecs_in     = usecs_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_cmd      = '{start: 1'b0, dividend: req_payload.duration_ms,
                       divisor: DIVISOR_W'(MS_PER_SEC)};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               reading_in = req_payload.counter_reading;
               if (req_payload.kind == KIND_START) begin
                  div_cmd.start = 1'b1;
                  after_in      = ST_MUL;
                  state_in      = ST_DIV;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = after_ff;
            end
         end
         ST_MUL: begin
            acc_in   = TICK_W'(secs_prod);
            usecs_in = usecs_calc;
            state_in = ST_SCALE_A;
         end
         ST_SCALE_A: begin
            acc_in           = acc_ff + TICK_W'(usecs_ff);
            div_cmd.start    = 1'b1;
            div_cmd.dividend = DIVIDEND_W'(scale_a_prod);
            div_cmd.divisor  = DIVISOR_W'(MS_PER_SEC);
            after_in         = ST_SCALE_B;
            state_in         = ST_DIV;
         end
         ST_SCALE_B: begin
            acc_in           = acc_ff + TICK_W'(div_status.quotient);
            div_cmd.start    = 1'b1;
            div_cmd.dividend = DIVIDEND_W'(scale_b_prod);
            div_cmd.divisor  = US_PER_SEC;
            after_in         = ST_SUM;
            state_in         = ST_DIV;
         end
         ST_SUM: begin
            target_in  = acc_ff + TICK_W'(div_status.quotient);
            elapsed_in = '0;
            last_in    = reading_ff;
            state_in   = ST_DONE;
         end
         ST_CHECK: begin
            if (elapsed_ff < target_ff) begin
               elapsed_in = elapsed_sat;
               last_in    = reading_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in.running       = (elapsed_ff < target_ff);
               rsp_in.elapsed_ticks = elapsed_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= ST_IDLE;
         reload_ff    <= RELOAD_RESET;
         last_ff      <= '0;
         elapsed_ff   <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         reload_ff    <= reload_in;
         last_ff      <= last_in;
         elapsed_ff   <= elapsed_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      reading_ff <= reading_in;
      acc_ff     <= acc_in;
      usecs_ff   <= usecs_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("accepted transfer did not start work");

   a_done_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("divider finished outside a divide step");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |=> elapsed_ff == '0 && last_ff == $past(reading_ff))
      else $error("start did not clear the elapsed count");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result loaded outside the done step");

   a_check_no_target_change: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |=> $stable(target_ff))
      else $error("check changed the target");

endmodule

// File: hw/rtl/mdt_divider.sv
module mdt_divider
   import mdt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  div_cmd_type     cmd,
   output div_status_type  status
);

   localparam int STEPS   = DIVIDEND_W / 2;
   localparam int COUNT_W = $clog2(STEPS);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0]   div_ff, div_in;

   logic [DIVISOR_W:0]     trial_a, trial_b;
   logic [DIVISOR_W-1:0]   rem_a, rem_b;
   logic                   bit_a, bit_b;

   always_comb begin
      trial_a = {rem_ff, quo_ff[DIVIDEND_W-1]};
      bit_a   = (trial_a >= {1'b0, div_ff});
      rem_a   = bit_a ? DIVISOR_W'(trial_a - {1'b0, div_ff}) : trial_a[DIVISOR_W-1:0];
      trial_b = {rem_a, quo_ff[DIVIDEND_W-2]};
      bit_b   = (trial_b >= {1'b0, div_ff});
      rem_b   = bit_b ? DIVISOR_W'(trial_b - {1'b0, div_ff}) : trial_b[DIVISOR_W-1:0];
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = cmd.dividend;
         rem_in   = '0;
         div_in   = cmd.divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIVIDEND_W-3:0], bit_a, bit_b};
         rem_in   = rem_b;
         count_in = COUNT_W'(count_ff + 1'b1);
         if (count_ff == COUNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a finished run");

endmodule
